@@ sv/polymul_pkg.sv @@
// ----------------------------------------------------------------------------
// polymul_pkg
// Shared types and constants for the dense polynomial multiplier: command
// codes, input and result words, and the controller/datapath link.
// ----------------------------------------------------------------------------
package polymul_pkg;

  // Default sizing
  localparam int DEF_MAX_TERMS = 32;
  localparam int DEF_COEF_BITS = 16;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 16;
  localparam int DEG_W    = 5;
  localparam int PROD_W   = 38;
  localparam int EXP_W    = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  // Input word
  typedef struct packed {
    logic        [CMD_W-1:0] command;
    logic        [POS_W-1:0] position;
    logic signed [VAL_W-1:0] coef_value;
    logic        [DEG_W-1:0] degree_a;
    logic        [DEG_W-1:0] degree_b;
  } pm_in_t;

  // Result word
  typedef struct packed {
    logic signed [PROD_W-1:0] product_coef;
    logic        [EXP_W-1:0]  exponent;
    logic                     last;
  } pm_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic run_init;
    logic exp_init;
    logic issue;
    logic emit;
    logic exp_dec;
  } pm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_term;
    logic last_exp;
    logic pipe_busy;
  } pm_sts_t;

endpackage

@@ sv/polymul_ctrl.sv @@
// ----------------------------------------------------------------------------
// polymul_ctrl
// Sequencer for the polynomial multiplier: takes command words, steps the
// datapath through each product exponent and its aligned term pairs.
// ----------------------------------------------------------------------------
module polymul_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [polymul_pkg::CMD_W-1:0] command,
  input  polymul_pkg::pm_sts_t         sts,
  output polymul_pkg::pm_cmd_t         cmd,
  output logic                         busy
);
  import polymul_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_ISSUE = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_LOAD_A: cmd.wr_a = 1'b1;
            CMD_LOAD_B: cmd.wr_b = 1'b1;
            CMD_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = S_SETUP;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd.exp_init = 1'b1;
        state_nxt    = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_term) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Emit once the last product has landed in the accumulator
        if (!sts.pipe_busy) begin
          cmd.emit = 1'b1;
          if (sts.last_exp) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.exp_dec = 1'b1;
            state_nxt   = S_SETUP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/polymul_dpath.sv @@
// ----------------------------------------------------------------------------
// polymul_dpath
// Coefficient stores, loop indices and the single multiply-accumulate unit
// of the polynomial multiplier, plus the result word register.
// ----------------------------------------------------------------------------
module polymul_dpath #(
  parameter int MAX_TERMS = polymul_pkg::DEF_MAX_TERMS,
  parameter int COEF_BITS = polymul_pkg::DEF_COEF_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  polymul_pkg::pm_in_t  in_word,
  input  polymul_pkg::pm_cmd_t cmd,
  output polymul_pkg::pm_sts_t sts,
  output logic                 out_valid,
  output polymul_pkg::pm_out_t out_word
);
  import polymul_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int EW = AW + 1;
  localparam int PW = 2 * COEF_BITS;
  localparam logic [POS_W:0]   TERMS_LIM = (POS_W+1)'(MAX_TERMS);
  localparam logic [DEG_W-1:0] DEG_MAX   = DEG_W'(MAX_TERMS - 1);
  localparam logic [AW-1:0]    IDX_MAX   = AW'(MAX_TERMS - 1);

  // Coefficient stores
  logic signed [COEF_BITS-1:0] a_mem [MAX_TERMS];
  logic signed [COEF_BITS-1:0] b_mem [MAX_TERMS];

  logic [AW-1:0]               da_r, db_r, ea_r;
  logic [EW-1:0]               e_r;
  logic signed [COEF_BITS-1:0] a_rd_r, b_rd_r;
  logic                        rd_vld_r, mul_vld_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [PROD_W-1:0]    acc_r;
  logic                        out_valid_r;
  pm_out_t                     out_word_r;

  logic                        pos_ok;
  logic signed [COEF_BITS-1:0] coef_w;
  logic [AW-1:0]               da_c, db_c;
  logic [AW-1:0]               ea_lo, ea_hi;
  logic [AW-1:0]               a_addr, b_addr;

  // Fit the loaded value to the store width; drop loads beyond the store
  assign coef_w = COEF_BITS'(in_word.coef_value);
  assign pos_ok = ({1'b0, in_word.position} < TERMS_LIM);

  // Saturate degrees to the store depth
  assign da_c = (in_word.degree_a > DEG_MAX) ? IDX_MAX : in_word.degree_a[AW-1:0];
  assign db_c = (in_word.degree_b > DEG_MAX) ? IDX_MAX : in_word.degree_b[AW-1:0];

  // Range of A exponents that pair with a B term for the current exponent
  assign ea_lo = (e_r > EW'(db_r)) ? AW'(e_r - EW'(db_r)) : '0;
  assign ea_hi = (e_r < EW'(da_r)) ? AW'(e_r) : da_r;

  // Slot 0 holds the highest degree term
  assign a_addr = da_r - ea_r;
  assign b_addr = db_r - AW'(e_r - EW'(ea_r));

  // Store writes
  always_ff @(posedge clk) begin
    if (cmd.wr_a && pos_ok) begin
      a_mem[in_word.position[AW-1:0]] <= coef_w;
    end
    if (cmd.wr_b && pos_ok) begin
      b_mem[in_word.position[AW-1:0]] <= coef_w;
    end
  end

  // Store reads
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_rd_r <= a_mem[a_addr];
      b_rd_r <= b_mem[b_addr];
    end
  end

  // Loop indices
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      da_r <= da_c;
      db_r <= db_c;
      e_r  <= EW'(da_c) + EW'(db_c);
    end else if (cmd.exp_dec) begin
      e_r  <= e_r - EW'(1);
    end
    if (cmd.exp_init) begin
      ea_r <= ea_lo;
    end else if (cmd.issue) begin
      ea_r <= ea_r + AW'(1);
    end
  end

  // Multiply, then accumulate at full result width
  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (cmd.exp_init) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + PROD_W'(prod_r);
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r.product_coef <= acc_r;
      out_word_r.exponent     <= EXP_W'(e_r);
      out_word_r.last         <= (e_r == '0);
    end
  end

  assign sts.last_term = (ea_r == ea_hi);
  assign sts.last_exp  = (e_r == '0);
  assign sts.pipe_busy = rd_vld_r | mul_vld_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sv/polynomial_multiply.sv @@
// ----------------------------------------------------------------------------
// polynomial_multiply
// Dense polynomial multiplier over signed Q7.8 coefficients.
//
// Input: a word is taken at a clock edge with start high and busy low.
// Load A / load B words write one coefficient by position (0 is the highest
// degree term); busy stays low, so loads may follow each other in every
// cycle. A run word carries both degrees and raises busy.
// Output: out_valid marks each result word for exactly one cycle, highest
// exponent first, last set on the constant term. The receiver cannot stall.
// Timing: one shared multiply-accumulate unit takes one term pair a cycle
// while an exponent issues; each exponent passes through set-up, issue of
// its aligned pairs, store read, multiply, accumulate and emit, so the unit
// pauses between exponents. busy falls in the cycle the last result word
// is shown.
// Reset: returns the sequencer to idle and drops any run in flight; the
// coefficient stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module polynomial_multiply #(
  parameter int MAX_TERMS = polymul_pkg::DEF_MAX_TERMS,
  parameter int COEF_BITS = polymul_pkg::DEF_COEF_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  polymul_pkg::pm_in_t  in_word,
  output logic                 out_valid,
  output polymul_pkg::pm_out_t out_word
);
  import polymul_pkg::*;

  pm_cmd_t cmd;
  pm_sts_t sts;

  // Sequencer
  polymul_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_word.command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Stores and multiply-accumulate
  polymul_dpath #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_BITS (COEF_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ sv/polymul_checker.sv @@
// ----------------------------------------------------------------------------
// polymul_checker
// Port-level checks for the polynomial multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module polymul_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input polymul_pkg::pm_in_t  in_word,
  input logic                 out_valid,
  input polymul_pkg::pm_out_t out_word
);
  import polymul_pkg::*;

  // A taken run word starts a run
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.command == CMD_RUN) |=> busy)
    else $error("run word did not raise busy");

  // A taken load word leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.command != CMD_RUN) |=> !busy)
    else $error("load word raised busy");

  // Results come only out of a run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word outside a run");

  // The final word ends the run, any other keeps it going
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last != busy))
    else $error("last marker and busy disagree");

  // Last marks the constant term only
  a_last_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last == (out_word.exponent == '0)))
    else $error("last marker on a non-constant term");

endmodule

bind polynomial_multiply polymul_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
